// ===== design/base64url_stream_codec_defines.svh =====
// ---------------------------------------------------------------------------
// base64url_stream_codec_defines.svh
// Assertion macros used by the codec's checker.
// ---------------------------------------------------------------------------
`ifndef BASE64URL_STREAM_CODEC_DEFINES_SVH
`define BASE64URL_STREAM_CODEC_DEFINES_SVH

// same-cycle implication
`define B64U_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("codec assertion failed");

// next-cycle implication
`define B64U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("codec assertion failed");

`endif

// ===== design/b64u_pkg.sv =====
// ---------------------------------------------------------------------------
// b64u_pkg
// Types, constants and alphabet functions of the base64url codec.
// ---------------------------------------------------------------------------
package b64u_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// one group to be serialized by the back end
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  last;  // index of the last word of the group
		logic        dir;
		logic        eom;
		logic        bad;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] six;
	} six_t;

	function automatic logic [7:0] six_to_char(input logic [5:0] six);
		logic [7:0] c;
		c = 8'h5F;
		if (six < 6'd26)
			c = 8'(8'h41 + {2'b00, six});
		else if (six < 6'd52)
			c = 8'(8'h61 + {2'b00, six} - 8'd26);
		else if (six < 6'd62)
			c = 8'(8'h30 + {2'b00, six} - 8'd52);
		else if (six == 6'd62)
			c = 8'h2D;
		return c;
	endfunction

	function automatic six_t char_to_six(input logic [7:0] c);
		six_t r;
		r.ok  = 1'b1;
		r.six = 6'd0;
		if (c inside {[8'h41:8'h5A]})
			r.six = 6'(c - 8'h41);
		else if (c inside {[8'h61:8'h7A]})
			r.six = 6'(c - 8'h61 + 8'd26);
		else if (c inside {[8'h30:8'h39]})
			r.six = 6'(c - 8'h30 + 8'd52);
		else if (c == 8'h2D)
			r.six = 6'd62;
		else if (c == 8'h5F)
			r.six = 6'd63;
		else
			r.ok = 1'b0;
		return r;
	endfunction

endpackage

// ===== design/b64u_queue.sv =====
// ---------------------------------------------------------------------------
// b64u_queue
// Small job queue between the front and back ends.
// ---------------------------------------------------------------------------
module b64u_queue #(
	parameter int DEPTH = b64u_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  b64u_pkg::job_t wr_data,
	input  logic           rd_en,
	output b64u_pkg::job_t rd_data,
	output logic           full,
	output logic           empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64u_pkg::job_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== design/b64u_front.sv =====
// ---------------------------------------------------------------------------
// b64u_front
// Accepts words, gathers groups, and posts finished groups as jobs.
// ---------------------------------------------------------------------------
module b64u_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr,
	input  logic           cfg_dir,
	input  logic           take,
	input  logic [7:0]     symbol,
	input  logic           final_req,
	output logic           job_push,
	output b64u_pkg::job_t job
);
	logic        dir_q;
	logic [23:0] bits_q;
	logic [1:0]  fill_q;
	logic        err_q;

	logic [23:0]     nbits;
	logic            emit;
	logic            nerr;
	b64u_pkg::six_t  dec;

	always_comb begin
		dec      = b64u_pkg::char_to_six(symbol);
		nbits    = bits_q;
		emit     = 1'b0;
		nerr     = err_q;
		job.bits = '0;
		job.last = '0;
		job.dir  = dir_q;
		job.eom  = final_req;
		job.bad  = err_q;
		if (dir_q == b64u_pkg::DIR_ENCODE) begin
			case (fill_q)
				2'd0:    nbits = bits_q | {symbol, 16'h0000};
				2'd1:    nbits = bits_q | {8'h00, symbol, 8'h00};
				default: nbits = bits_q | {16'h0000, symbol};
			endcase
			emit     = (fill_q == 2'd2) || final_req;
			job.bits = nbits;
			// n words = fill+2 on a short group, four on a full one
			job.last = (fill_q == 2'd2) ? 2'd3 : 2'(fill_q + 2'd1);
		end else begin
			nerr = err_q | !dec.ok;
			case (fill_q)
				2'd0:    nbits = bits_q | {dec.six, 18'h0};
				2'd1:    nbits = bits_q | {6'h0, dec.six, 12'h0};
				2'd2:    nbits = bits_q | {12'h0, dec.six, 6'h0};
				default: nbits = bits_q | {18'h0, dec.six};
			endcase
			emit    = (fill_q == 2'd3) || final_req;
			job.bad = nerr;
			if (final_req && fill_q == 2'd0) begin
				// lone trailing character: one zero word flagged bad
				job.bits = '0;
				job.last = 2'd0;
				job.bad  = 1'b1;
			end else begin
				job.bits = nbits;
				job.last = (fill_q == 2'd3) ? 2'd2 : 2'(fill_q - 2'd1);
			end
		end
	end

	assign job_push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= b64u_pkg::DIR_ENCODE;
			bits_q <= '0;
			fill_q <= '0;
			err_q  <= 1'b0;
		end else if (cfg_wr) begin
			dir_q  <= cfg_dir;
			bits_q <= '0;
			fill_q <= '0;
			err_q  <= 1'b0;
		end else if (take) begin
			err_q <= final_req ? 1'b0 : nerr;
			if (emit) begin
				bits_q <= '0;
				fill_q <= '0;
			end else begin
				bits_q <= nbits;
				fill_q <= fill_q + 2'd1;
			end
		end
	end
endmodule

// ===== design/b64u_back.sv =====
// ---------------------------------------------------------------------------
// b64u_back
// Serializes queued groups into one output word per cycle while the output is empty or popped.
// ---------------------------------------------------------------------------
module b64u_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64u_pkg::job_t job,
	input  logic           job_avail,
	output logic           job_pop,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     value,
	output logic           end_of_message,
	output logic           bad_input
);
	logic [1:0] idx_q;
	logic       out_vld_q;
	logic [7:0] value_q;
	logic       eom_q, bad_q;

	logic       adv, load, last_word;
	logic [5:0] six;
	logic [7:0] word;

	assign adv       = !out_vld_q || pop;
	assign load      = adv && job_avail;
	assign last_word = (idx_q == job.last);
	assign job_pop   = load && last_word;

	always_comb begin
		case (idx_q)
			2'd0:    six = job.bits[23:18];
			2'd1:    six = job.bits[17:12];
			2'd2:    six = job.bits[11:6];
			default: six = job.bits[5:0];
		endcase
		if (job.dir == b64u_pkg::DIR_ENCODE)
			word = b64u_pkg::six_to_char(six);
		else begin
			case (idx_q)
				2'd0:    word = job.bits[23:16];
				2'd1:    word = job.bits[15:8];
				default: word = job.bits[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= job_avail;
			if (load)
				idx_q <= last_word ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= word;
			eom_q   <= job.eom && last_word;
			bad_q   <= job.bad;
		end
	end

	assign empty          = !out_vld_q;
	assign value          = value_q;
	assign end_of_message = eom_q;
	assign bad_input      = bad_q;
endmodule

// ===== design/base64url_stream_codec.sv =====
// A word that completes a group is written to the job queue and then loaded into the output register.
// Throughput: one result word per cycle from the output register while pop is held; input one word
// per cycle while the job queue has room (in encode, each three-byte group yields four output words).
// Queue depth QUEUE_DEPTH groups sets how long input runs on while the output side stalls.
// Reset: arst_n clears direction to encode, the group state, the queue and the output valid state.
// ---------------------------------------------------------------------------
// base64url_stream_codec
// Streaming URL-safe base64 encoder/decoder without padding.
// ---------------------------------------------------------------------------
module base64url_stream_codec #(
	parameter int QUEUE_DEPTH = b64u_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] symbol,
	input  logic       final_req,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] value,
	output logic       end_of_message,
	output logic       bad_input,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	b64u_pkg::job_t f_job, q_job;
	logic f_push, q_empty, q_pop, take;

	// register writes must only arrive while idle; the block itself does not enforce it
	assign cfg_ready = 1'b1;
	assign take      = push && !full;

	b64u_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_dir   (cfg_data),
		.take      (take),
		.symbol    (symbol),
		.final_req (final_req),
		.job_push  (f_push),
		.job       (f_job)
	);

	b64u_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (f_job),
		.rd_en   (q_pop),
		.rd_data (q_job),
		.full    (full),
		.empty   (q_empty)
	);

	b64u_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job            (q_job),
		.job_avail      (!q_empty),
		.job_pop        (q_pop),
		.pop            (pop),
		.empty          (empty),
		.value          (value),
		.end_of_message (end_of_message),
		.bad_input      (bad_input)
	);
endmodule

// ===== design/b64u_checker.sv =====
// ---------------------------------------------------------------------------
// b64u_checker
// Port-level checks of the codec, bound to the top level.
// ---------------------------------------------------------------------------
`include "base64url_stream_codec_defines.svh"

module b64u_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] value,
	input logic       end_of_message,
	input logic       bad_input,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       cfg_data
);
	logic dir_q;
	logic enc_out;
	logic in_alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dir_q <= b64u_pkg::DIR_ENCODE;
		else if (cfg_valid && cfg_ready)
			dir_q <= cfg_data;
	end

	assign enc_out  = !empty && (dir_q == b64u_pkg::DIR_ENCODE);
	assign in_alpha = (value >= 8'h41 && value <= 8'h5A) ||
		(value >= 8'h61 && value <= 8'h7A) ||
		(value >= 8'h30 && value <= 8'h39) ||
		value == 8'h2D || value == 8'h5F;

	`B64U_ASSERT_IMPLY(a_enc_never_bad, clk, arst_n, enc_out, !bad_input)

	`B64U_ASSERT_IMPLY(a_enc_alphabet, clk, arst_n, enc_out, in_alpha)

	`B64U_ASSERT_NEXT(a_out_hold, clk, arst_n, !empty && !pop, !empty && $stable(value) && $stable(end_of_message) && $stable(bad_input))
endmodule

bind base64url_stream_codec b64u_checker u_b64u_checker (.*);

// ===== verif/base64url_stream_codec_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// base64url_stream_codec_tb
// Drives byte and character words through the codec in both directions and
// checks every result word against typed expectations or a cycle-free model of the group logic.
// ---------------------------------------------------------------------------
module base64url_stream_codec_tb;

	localparam int IDLE_PCT      = 32;
	localparam int RANDOM_ITEMS  = 150;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [8*64-1:0] URL_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

	typedef struct packed {
		logic [7:0] value;
		logic       eom;
		logic       bad;
	} word_t;

	typedef enum logic [1:0] {ROW_WORD, ROW_DIR} row_kind_t;

	// n_typed of 0 means the row is checked against the model only
	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  sym;
		logic        fin;
		logic [2:0]  n_typed;
		word_t [0:3] typed;
	} row_t;

	localparam int N_DIRECTED = 29;

	row_t directed_rows [N_DIRECTED] = '{
		// encode, right after reset
		'{ROW_WORD, 8'h00, 1'b1, 3'd2,
			'{'{8'h41, 1'b0, 1'b0}, '{8'h41, 1'b1, 1'b0}, '0, '0}},
		'{ROW_WORD, 8'hFF, 1'b1, 3'd2,
			'{'{8'h5F, 1'b0, 1'b0}, '{8'h77, 1'b1, 1'b0}, '0, '0}},
		'{ROW_WORD, 8'hFF, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'hFF, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'hFF, 1'b1, 3'd4,
			'{'{8'h5F, 1'b0, 1'b0}, '{8'h5F, 1'b0, 1'b0},
			  '{8'h5F, 1'b0, 1'b0}, '{8'h5F, 1'b1, 1'b0}}},
		'{ROW_WORD, 8'h00, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h00, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h00, 1'b0, 3'd4,
			'{'{8'h41, 1'b0, 1'b0}, '{8'h41, 1'b0, 1'b0},
			  '{8'h41, 1'b0, 1'b0}, '{8'h41, 1'b0, 1'b0}}},
		'{ROW_WORD, 8'h4D, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h61, 1'b1, 3'd0, '0},
		// partial group dropped by the direction write
		'{ROW_WORD, 8'h12, 1'b0, 3'd0, '0},
		'{ROW_DIR, 8'(b64u_pkg::DIR_DECODE), 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h54, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h57, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h46, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h75, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h41, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h41, 1'b1, 3'd1, '{'{8'h00, 1'b1, 1'b0}, '0, '0, '0}},
		'{ROW_WORD, 8'h5F, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h5F, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h5F, 1'b1, 3'd2,
			'{'{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b0}, '0, '0}},
		// invalid character inside a group
		'{ROW_WORD, 8'h80, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h41, 1'b1, 3'd1, '{'{8'h00, 1'b1, 1'b1}, '0, '0, '0}},
		// dangling single character, invalid and valid
		'{ROW_WORD, 8'h2A, 1'b1, 3'd1, '{'{8'h00, 1'b1, 1'b1}, '0, '0, '0}},
		'{ROW_WORD, 8'h51, 1'b1, 3'd1, '{'{8'h00, 1'b1, 1'b1}, '0, '0, '0}},
		// errored message aborted, flag must not leak into the next one
		'{ROW_WORD, 8'h3D, 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h78, 1'b0, 3'd0, '0},
		'{ROW_DIR, 8'(b64u_pkg::DIR_ENCODE), 1'b0, 3'd0, '0},
		'{ROW_WORD, 8'h00, 1'b1, 3'd2,
			'{'{8'h41, 1'b0, 1'b0}, '{8'h41, 1'b1, 1'b0}, '0, '0}}
	};

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       push           = 1'b0;
	logic       full;
	logic [7:0] symbol         = 8'h00;
	logic       final_req      = 1'b0;
	logic       empty;
	logic       pop            = 1'b0;
	logic [7:0] value;
	logic       end_of_message;
	logic       bad_input;
	logic       cfg_valid      = 1'b0;
	logic       cfg_ready;
	logic       cfg_data       = 1'b0;

	// model state
	logic        cur_dir  = b64u_pkg::DIR_ENCODE;
	logic [23:0] grp_bits = '0;
	int          grp_fill = 0;
	logic        err_seen = 1'b0;

	word_t expected_words [$];
	int    err_count  = 0;
	int    items_sent = 0;
	logic  steady     = 1'b0;

	base64url_stream_codec dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.symbol         (symbol),
		.final_req      (final_req),
		.empty          (empty),
		.pop            (pop),
		.value          (value),
		.end_of_message (end_of_message),
		.bad_input      (bad_input),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] alpha_char(input int six);
		return URL_ALPHABET[8*(63-six) +: 8];
	endfunction

	// 64 for anything outside the alphabet
	function automatic int six_of_char(input logic [7:0] c);
		int six;
		six = 64;
		for (int i = 0; i < 64; i++)
			if (alpha_char(i) == c)
				six = i;
		return six;
	endfunction

	function automatic int codec_step(input logic [7:0] sym, input logic fin,
			output word_t w [4]);
		int fill;
		int cnt;
		int n;
		int six;
		n    = 0;
		fill = grp_fill;
		cnt  = fill + 1;
		w    = '{default: '0};
		if (cur_dir == b64u_pkg::DIR_ENCODE) begin
			grp_bits |= 24'(sym) << (16 - 8*fill);
			if (cnt == 3)
				n = 4;
			else if (fin)
				n = cnt + 1;
			for (int k = 0; k < n; k++) begin
				six = int'((grp_bits >> (18 - 6*k)) & 24'h3F);
				w[k].value = alpha_char(six);
				w[k].eom   = fin && (k == n - 1);
				w[k].bad   = err_seen;
			end
			if (cnt == 3 || fin) begin
				grp_bits = '0;
				grp_fill = 0;
			end else begin
				grp_fill = cnt;
			end
		end else begin
			six = six_of_char(sym);
			if (six > 63) begin
				err_seen = 1'b1;
				six      = 0;
			end
			grp_bits |= 24'(six) << (18 - 6*fill);
			if (cnt == 4)
				n = 3;
			else if (fin)
				n = cnt - 1;
			if (fin && cnt == 1) begin
				err_seen = 1'b1;
				w[0]     = '{8'h00, 1'b1, 1'b1};
				n        = 1;
			end else begin
				for (int k = 0; k < n; k++) begin
					w[k].value = grp_bits[23 - 8*k -: 8];
					w[k].eom   = fin && (k == n - 1);
					w[k].bad   = err_seen;
				end
			end
			if (cnt == 4 || fin) begin
				grp_bits = '0;
				grp_fill = 0;
			end else begin
				grp_fill = cnt;
			end
		end
		if (fin)
			err_seen = 1'b0;
		return n;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		err_count++;
	endtask

	always @(negedge clk) begin
		pop <= arst_n && (steady || $urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		word_t want;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word value=%02h eom=%0b bad=%0b",
					value, end_of_message, bad_input));
			end else begin
				want = expected_words.pop_front();
				if (value !== want.value)
					report_mismatch($sformatf("value %02h, want %02h", value, want.value));
				if (end_of_message !== want.eom)
					report_mismatch($sformatf("end_of_message %0b, want %0b",
						end_of_message, want.eom));
				if (bad_input !== want.bad)
					report_mismatch($sformatf("bad_input %0b, want %0b", bad_input, want.bad));
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [7:0] sym, input logic fin,
			input int n_typed, input word_t [0:3] typed);
		word_t predicted [4];
		int    n;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push      <= 1'b1;
		symbol    <= sym;
		final_req <= fin;
		do @(posedge clk); while (full);
		n = codec_step(sym, fin, predicted);
		if (n_typed == 0) begin
			for (int k = 0; k < n; k++)
				expected_words.insert(expected_words.size(), predicted[k]);
		end else begin
			for (int k = 0; k < n_typed; k++)
				expected_words.insert(expected_words.size(), typed[k]);
		end
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_direction(input logic d);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cur_dir  = d;
		grp_bits = '0;
		grp_fill = 0;
		err_seen = 1'b0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_message(input int len, input logic noisy, input logic open_end);
		logic [7:0] sym;
		for (int i = 0; i < len; i++) begin
			if (cur_dir == b64u_pkg::DIR_ENCODE || (noisy && $urandom_range(7) == 0))
				sym = 8'($urandom_range(255));
			else
				sym = alpha_char($urandom_range(63));
			send_word(sym, (i == len - 1) && !open_end, 0, '0);
		end
	endtask

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int   phase;
		int   msgs;
		int   len;
		logic noisy;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].kind == ROW_DIR) begin
				settle();
				write_direction(directed_rows[i].sym[0]);
			end else begin
				send_word(directed_rows[i].sym, directed_rows[i].fin,
					directed_rows[i].n_typed, directed_rows[i].typed);
			end
		end

		// random phases; first two pin both directions, phase 3 runs without random push or pop idles
		items_sent = 0;
		phase      = 0;
		while (items_sent < RANDOM_ITEMS) begin
			settle();
			write_direction(phase < 2 ? logic'(phase % 2) : logic'($urandom_range(1)));
			steady <= (phase == 3);
			msgs = $urandom_range(2, 6);
			for (int m = 0; m < msgs; m++) begin
				len   = $urandom_range(1, 10);
				noisy = $urandom_range(99) < 20;
				if (cur_dir == b64u_pkg::DIR_DECODE && !noisy && len % 4 == 1)
					len++;
				send_message(len, noisy, (m == msgs - 1) && $urandom_range(3) == 0);
			end
			phase++;
		end
		settle();

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== base64url_stream_codec.f =====
+incdir+design
design/b64u_pkg.sv
design/b64u_queue.sv
design/b64u_front.sv
design/b64u_back.sv
design/base64url_stream_codec.sv
design/b64u_checker.sv
verif/base64url_stream_codec_tb.sv
